// ----- rtl/core/daily_series_window_statistics_core_macros.svh -----
// Assertion macros for the daily series window statistics core.
// Used by the top level only; expects signals named clk and rst in scope.
`ifndef DAILY_SERIES_WINDOW_STATISTICS_CORE_MACROS_SVH
`define DAILY_SERIES_WINDOW_STATISTICS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/dswc_pkg.sv -----
// Shared types and constants for the daily series window statistics core.
// Holds field widths, stream packing offsets, codes and the control structs.
`default_nettype none

package dswc_pkg;

  localparam int unsigned MAX_DAYS_DEF   = 512;
  localparam int unsigned COUNT_BITS_DEF = 24;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned DAY_W    = 9;
  localparam int unsigned WIN_W    = 10;
  localparam int unsigned GAP_W    = 9;
  localparam int unsigned IN_CNT_W = 24;

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WSUM_W   = 33;
  localparam int unsigned MEAN_W   = 32;
  localparam int unsigned SD_W     = 32;
  localparam int unsigned GROWTH_W = 48;
  localparam int unsigned DAYS_W   = 10;

  localparam int unsigned GROWTH_SCALE = 100 * 256;
  localparam int unsigned GSCALE_W     = 15;

  localparam int unsigned IN_DAY_LO   = 0;
  localparam int unsigned IN_WIN_LO   = IN_DAY_LO + DAY_W;
  localparam int unsigned IN_GAP_LO   = IN_WIN_LO + WIN_W;
  localparam int unsigned IN_ND_LO    = IN_GAP_LO + GAP_W;
  localparam int unsigned IN_NC_LO    = IN_ND_LO + IN_CNT_W;
  localparam int unsigned S_TDATA_W   = 80;
  localparam int unsigned U_OP_LO     = 0;
  localparam int unsigned U_KIND_BIT  = OP_W;
  localparam int unsigned S_TUSER_W   = OP_W + 1;

  localparam int unsigned O_STATUS_LO = 0;
  localparam int unsigned O_WSUM_LO   = O_STATUS_LO + STATUS_W;
  localparam int unsigned O_MEAN_LO   = O_WSUM_LO + WSUM_W;
  localparam int unsigned O_SD_LO     = O_MEAN_LO + MEAN_W;
  localparam int unsigned O_GROWTH_LO = O_SD_LO + SD_W;
  localparam int unsigned O_INF_BIT   = O_GROWTH_LO + GROWTH_W;
  localparam int unsigned O_DAYS_LO   = O_INF_BIT + 1;
  localparam int unsigned M_TDATA_W   = 160;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD = 2'd0,
    OP_STATS  = 2'd1,
    OP_GROWTH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_WINDOW = 2'd1,
    ST_BAD_GAP    = 2'd2,
    ST_BAD_DAY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DIV_MEAN   = 2'd0,
    DIV_SD     = 2'd1,
    DIV_GROWTH = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     check;
    logic     rec_read;
    logic     rec_write;
    logic     acc_start;
    logic     acc_early;
    logic     mul;
    logic     div_start;
    div_sel_t div_sel;
    logic     sqrt_start;
    logic     result;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic err;
    logic acc_done;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/dswc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the datapath for the mean, deviation and growth.
`default_nettype none

module dswc_div #(
  parameter int unsigned DW = 51,
  parameter int unsigned VW = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [VW:0]     rem_t;
  logic            ge;

  assign rem_t = {rem, quot[DW-1]};
  assign ge    = rem_t >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      rem  <= ge ? VW'(rem_t - {1'b0, dvs}) : VW'(rem_t);
      quot <= {quot[DW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dswc_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle.
// Standalone; used by the datapath for the standard deviation.
`default_nettype none

module dswc_sqrt #(
  parameter int unsigned RAD_W = 84
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [RAD_W-1:0]   rad,
  output logic               done,
  output logic [RAD_W/2-1:0] root
);

  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned RW     = ROOT_W + 1;
  localparam int unsigned CNTW   = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0] rad_sh;
  logic [RW-1:0]    rem;
  logic [CNTW-1:0]  cnt;
  logic             busy;
  logic [RW+1:0]    rem_t;
  logic [RW+1:0]    trial;
  logic             ge;

  assign rem_t = {rem, rad_sh[RAD_W-1 -: 2]};
  assign trial = (RW + 2)'({root, 2'b01});
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= rad_sh << 2;
      rem    <= ge ? RW'(rem_t - trial) : RW'(rem_t);
      root   <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dswc_datapath.sv -----
// Datapath: day store, window accumulator, products, result and output registers.
// Depends on dswc_pkg, dswc_div and dswc_sqrt; driven by dswc_ctrl commands.
`default_nettype none

module dswc_datapath #(
  parameter int unsigned MAX_DAYS   = dswc_pkg::MAX_DAYS_DEF,
  parameter int unsigned COUNT_BITS = dswc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dswc_pkg::cmd_t                      cmd,
  output dswc_pkg::stat_t                     stat,
  input  logic [dswc_pkg::OP_W-1:0]           op,
  input  logic [dswc_pkg::DAY_W-1:0]          day,
  input  logic [dswc_pkg::WIN_W-1:0]          window_length,
  input  logic [dswc_pkg::GAP_W-1:0]          growth_interval,
  input  logic                                kind,
  input  logic signed [dswc_pkg::IN_CNT_W-1:0] new_deaths,
  input  logic signed [dswc_pkg::IN_CNT_W-1:0] new_cases,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [dswc_pkg::STATUS_W-1:0]       out_status,
  output logic [dswc_pkg::WSUM_W-1:0]         out_wsum,
  output logic [dswc_pkg::MEAN_W-1:0]         out_mean,
  output logic [dswc_pkg::SD_W-1:0]           out_sd,
  output logic [dswc_pkg::GROWTH_W-1:0]       out_growth,
  output logic                                out_inf,
  output logic [dswc_pkg::DAYS_W-1:0]         out_days
);

  import dswc_pkg::*;

  localparam int unsigned CB     = COUNT_BITS;
  localparam int unsigned AW     = $clog2(MAX_DAYS);
  localparam int unsigned CW     = $clog2(MAX_DAYS + 1);
  localparam int unsigned XW     = ((CW > 11) ? CW : 11) + 1;
  localparam int unsigned EW     = ((CB > IN_CNT_W) ? CB : IN_CNT_W) + 1;
  localparam int unsigned SUM_W  = CB + WIN_W;
  localparam int unsigned SQ_W   = 2 * CB;
  localparam int unsigned S2_W   = 2 * CB + WIN_W;
  localparam int unsigned NS2_W  = S2_W + WIN_W;
  localparam int unsigned SS_W   = 2 * SUM_W;
  localparam int unsigned V_W    = (NS2_W > SS_W) ? NS2_W : SS_W;
  localparam int unsigned RAD_W0 = V_W + 16;
  localparam int unsigned RAD_W  = RAD_W0 + (RAD_W0 % 2);
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned DIFF_W = SUM_W + 1;
  localparam int unsigned GNUM_W = DIFF_W + GSCALE_W;
  localparam int unsigned DW_A   = (GNUM_W > SUM_W + 8) ? GNUM_W : SUM_W + 8;
  localparam int unsigned DIV_DW = (DW_A > ROOT_W) ? DW_A : ROOT_W;
  localparam int unsigned DIV_VW = SUM_W;
  localparam int unsigned BIGW   = (SUM_W > WSUM_W) ? SUM_W : WSUM_W;

  localparam logic signed [EW-1:0]   CMAX     = EW'({(CB-1){1'b1}});
  localparam logic signed [EW-1:0]   CMIN     = ~CMAX;
  localparam logic signed [BIGW-1:0] WS_MAX   = BIGW'({(WSUM_W-1){1'b1}});
  localparam logic signed [BIGW-1:0] WS_MIN   = ~WS_MAX;
  localparam logic [DIV_DW-1:0]      MEAN_PMAX = DIV_DW'({(MEAN_W-1){1'b1}});
  localparam logic [DIV_DW-1:0]      MEAN_NMAX = MEAN_PMAX + 1'b1;
  localparam logic [DIV_DW-1:0]      SD_MAX    = DIV_DW'({SD_W{1'b1}});
  localparam logic [DIV_DW-1:0]      G_PMAX    = DIV_DW'({(GROWTH_W-1){1'b1}});
  localparam logic [DIV_DW-1:0]      G_NMAX    = G_PMAX + 1'b1;

  function automatic logic [CB-1:0] sat_cnt(input logic signed [EW-1:0] a,
                                            input logic signed [EW-1:0] b);
    logic signed [EW-1:0] s;
    s = a + b;
    if (s > CMAX) return CMAX[CB-1:0];
    if (s < CMIN) return CMIN[CB-1:0];
    return s[CB-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] mag_sum(input logic signed [SUM_W-1:0] s);
    return s[SUM_W-1] ? SUM_W'(~s + 1'b1) : SUM_W'(s);
  endfunction

  function automatic logic [WSUM_W-1:0] sat_wsum(input logic signed [SUM_W-1:0] s);
    logic signed [BIGW-1:0] w;
    w = BIGW'(s);
    if (w > WS_MAX) return WS_MAX[WSUM_W-1:0];
    if (w < WS_MIN) return WS_MIN[WSUM_W-1:0];
    return w[WSUM_W-1:0];
  endfunction

  op_t                  op_r;
  logic [DAY_W-1:0]     day_r;
  logic [WIN_W-1:0]     n_r;
  logic [GAP_W-1:0]     g_r;
  logic                 kind_r;
  logic signed [IN_CNT_W-1:0] nd_r;
  logic signed [IN_CNT_W-1:0] nc_r;
  logic [CW-1:0]        day_count;

  logic [2*CB-1:0]      mem [MAX_DAYS];
  logic [2*CB-1:0]      rd_data;
  logic [AW-1:0]        mem_raddr;
  logic [2*CB-1:0]      mem_wdata;
  logic [AW-1:0]        rec_idx;

  logic [XW-1:0]        day1;
  logic [XW-1:0]        nn;
  logic [XW-1:0]        gg;
  logic [XW-1:0]        dc;
  logic                 rec_in_range;
  logic                 rec_append;
  status_t              err_code;

  logic signed [CB-1:0] old_d;
  logic signed [CB-1:0] old_c;

  logic                 acc_active;
  logic [AW-1:0]        acc_addr;
  logic [WIN_W-1:0]     acc_left;
  logic                 rd_pend;
  logic                 sq_valid;
  logic [SQ_W-1:0]      sq_r;
  logic signed [SUM_W-1:0] acc_s;
  logic [S2_W-1:0]      acc_s2;
  logic [XW-1:0]        acc_first;
  logic signed [CB-1:0] acc_v;
  logic [CB-1:0]        acc_mag;
  logic                 acc_done;

  logic signed [SUM_W-1:0] s1_r;
  logic [NS2_W-1:0]     ns2_r;
  logic [SS_W-1:0]      ss_r;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]    mag_diff;
  logic [GNUM_W-1:0]    gnum;

  logic [DIV_DW-1:0]    div_a;
  logic [DIV_VW-1:0]    div_b;
  logic [DIV_DW-1:0]    div_q;
  logic                 div_done;
  div_sel_t             sel_r;
  logic                 gneg_r;
  logic                 s0_zero_r;

  logic [RAD_W-1:0]     rad;
  logic [ROOT_W-1:0]    root;
  logic                 sqrt_done;

  status_t              status_r;
  logic [WSUM_W-1:0]    wsum_r;
  logic [MEAN_W-1:0]    mean_r;
  logic [SD_W-1:0]      sd_r;
  logic [GROWTH_W-1:0]  growth_r;
  logic                 inf_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(op);
      day_r  <= day;
      n_r    <= window_length;
      g_r    <= growth_interval;
      kind_r <= kind;
      nd_r   <= new_deaths;
      nc_r   <= new_cases;
    end
  end

  assign day1         = XW'(day_r) + 1'b1;
  assign nn           = XW'(n_r);
  assign gg           = XW'(g_r);
  assign dc           = XW'(day_count);
  assign rec_in_range = XW'(day_r) < dc;
  assign rec_append   = (XW'(day_r) == dc) && (dc < XW'(MAX_DAYS));
  assign rec_idx      = AW'(day_r);

  always_comb begin
    err_code = ST_OK;
    if (op_r == OP_RECORD) begin
      if (!rec_in_range && !rec_append) err_code = ST_BAD_DAY;
    end else if (op_r == OP_STATS || op_r == OP_GROWTH) begin
      priority if (op_r == OP_GROWTH && (g_r == '0 || gg > day1)) err_code = ST_BAD_GAP;
      else if (n_r == '0 || nn > day1) err_code = ST_BAD_WINDOW;
      else if (XW'(day_r) >= dc) err_code = ST_BAD_DAY;
      else if (op_r == OP_GROWTH && (nn + gg > day1)) err_code = ST_BAD_WINDOW;
      else err_code = ST_OK;
    end
  end

  // Store: deaths in the low half of a word, cases in the high half.
  assign old_d     = rec_in_range ? signed'(rd_data[CB-1:0]) : '0;
  assign old_c     = rec_in_range ? signed'(rd_data[2*CB-1:CB]) : '0;
  assign mem_wdata = {sat_cnt(EW'(old_c), EW'(nc_r)), sat_cnt(EW'(old_d), EW'(nd_r))};
  assign mem_raddr = cmd.rec_read ? rec_idx : acc_addr;

  always_ff @(posedge clk) begin
    if (cmd.rec_write) mem[rec_idx] <= mem_wdata;
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day_count <= '0;
    end else if (cmd.rec_write && !rec_in_range) begin
      day_count <= day_count + 1'b1;
    end
  end

  assign acc_first = day1 - nn - (cmd.acc_early ? gg : '0);
  assign acc_v     = kind_r ? signed'(rd_data[2*CB-1:CB]) : signed'(rd_data[CB-1:0]);
  assign acc_mag   = acc_v[CB-1] ? CB'(~acc_v + 1'b1) : CB'(acc_v);
  assign acc_done  = acc_active && (acc_left == '0) && !rd_pend && !sq_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_active <= 1'b0;
      rd_pend    <= 1'b0;
      sq_valid   <= 1'b0;
    end else if (cmd.acc_start) begin
      acc_active <= 1'b1;
      rd_pend    <= 1'b0;
      sq_valid   <= 1'b0;
    end else if (acc_active) begin
      rd_pend  <= acc_left != '0;
      sq_valid <= rd_pend;
      if (acc_done) acc_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_start) begin
      acc_addr <= AW'(acc_first);
      acc_left <= n_r;
      acc_s    <= '0;
      acc_s2   <= '0;
    end else if (acc_active) begin
      if (acc_left != '0) begin
        acc_addr <= acc_addr + 1'b1;
        acc_left <= acc_left - 1'b1;
      end
      if (rd_pend) begin
        acc_s <= acc_s + SUM_W'(acc_v);
        sq_r  <= SQ_W'(acc_mag) * SQ_W'(acc_mag);
      end
      if (sq_valid) acc_s2 <= acc_s2 + S2_W'(sq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      s1_r  <= acc_s;
      ns2_r <= NS2_W'(n_r) * NS2_W'(acc_s2);
      ss_r  <= SS_W'(mag_sum(acc_s)) * SS_W'(mag_sum(acc_s));
    end
  end

  assign diff     = DIFF_W'(s1_r) - DIFF_W'(acc_s);
  assign mag_diff = diff[DIFF_W-1] ? DIFF_W'(~diff + 1'b1) : DIFF_W'(diff);
  assign gnum     = GNUM_W'(mag_diff) * GNUM_W'(GROWTH_SCALE);
  assign rad      = RAD_W'(V_W'(ns2_r) - V_W'(ss_r)) << 16;

  always_comb begin
    unique case (cmd.div_sel)
      DIV_MEAN: begin
        div_a = DIV_DW'({mag_sum(s1_r), 8'b0});
        div_b = DIV_VW'(n_r);
      end
      DIV_SD: begin
        div_a = DIV_DW'(root);
        div_b = DIV_VW'(n_r);
      end
      DIV_GROWTH: begin
        div_a = DIV_DW'(gnum);
        div_b = DIV_VW'(mag_sum(acc_s));
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  dswc_div #(
    .DW(DIV_DW),
    .VW(DIV_VW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(div_a),
    .divisor (div_b),
    .done    (div_done),
    .quot    (div_q)
  );

  dswc_sqrt #(
    .RAD_W(RAD_W)
  ) u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.sqrt_start),
    .rad  (rad),
    .done (sqrt_done),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sel_r     <= cmd.div_sel;
      gneg_r    <= diff[DIFF_W-1] != acc_s[SUM_W-1];
      s0_zero_r <= acc_s == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      status_r <= err_code;
      wsum_r   <= '0;
      mean_r   <= '0;
      sd_r     <= '0;
      growth_r <= '0;
      inf_r    <= 1'b0;
    end else if (cmd.mul) begin
      wsum_r <= sat_wsum(acc_s);
    end else if (div_done) begin
      unique case (sel_r)
        DIV_MEAN: begin
          if (!s1_r[SUM_W-1]) begin
            mean_r <= (div_q > MEAN_PMAX) ? MEAN_W'(MEAN_PMAX) : MEAN_W'(div_q);
          end else begin
            mean_r <= (div_q > MEAN_NMAX) ? MEAN_W'(MEAN_NMAX) : MEAN_W'(~div_q + 1'b1);
          end
        end
        DIV_SD: begin
          sd_r <= (div_q > SD_MAX) ? SD_W'(SD_MAX) : SD_W'(div_q);
        end
        DIV_GROWTH: begin
          if (s0_zero_r) begin
            growth_r <= GROWTH_W'(G_PMAX);
            inf_r    <= 1'b1;
          end else if (!gneg_r) begin
            growth_r <= (div_q > G_PMAX) ? GROWTH_W'(G_PMAX) : GROWTH_W'(div_q);
          end else begin
            growth_r <= (div_q > G_NMAX) ? GROWTH_W'(G_NMAX) : GROWTH_W'(~div_q + 1'b1);
          end
        end
        default: begin
          inf_r <= inf_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_status <= status_r;
      out_wsum   <= wsum_r;
      out_mean   <= mean_r;
      out_sd     <= sd_r;
      out_growth <= growth_r;
      out_inf    <= inf_r;
      out_days   <= DAYS_W'(day_count);
    end
  end

  assign stat.op        = op_r;
  assign stat.err       = err_code != ST_OK;
  assign stat.acc_done  = acc_done;
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- rtl/core/dswc_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
// Depends on dswc_pkg for the command and status structs.
`default_nettype none

module dswc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dswc_pkg::stat_t stat,
  output dswc_pkg::cmd_t  cmd
);

  import dswc_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_CHECK  = 18'h00002,
    S_REC_RD = 18'h00004,
    S_REC_WR = 18'h00008,
    S_ACC1   = 18'h00010,
    S_ACC1_W = 18'h00020,
    S_MUL    = 18'h00040,
    S_MEAN   = 18'h00080,
    S_MEAN_W = 18'h00100,
    S_ROOT   = 18'h00200,
    S_ROOT_W = 18'h00400,
    S_SD     = 18'h00800,
    S_SD_W   = 18'h01000,
    S_ACC0   = 18'h02000,
    S_ACC0_W = 18'h04000,
    S_GROW   = 18'h08000,
    S_GROW_W = 18'h10000,
    S_DONE   = 18'h20000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        priority if (stat.err || stat.op == OP_NONE) state_next = S_DONE;
        else if (stat.op == OP_RECORD) state_next = S_REC_RD;
        else state_next = S_ACC1;
      end
      S_REC_RD: begin
        cmd.rec_read = 1'b1;
        state_next   = S_REC_WR;
      end
      S_REC_WR: begin
        cmd.rec_write = 1'b1;
        state_next    = S_DONE;
      end
      S_ACC1: begin
        cmd.acc_start = 1'b1;
        state_next    = S_ACC1_W;
      end
      S_ACC1_W: begin
        if (stat.acc_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_MEAN;
      end
      S_MEAN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
        state_next    = S_MEAN_W;
      end
      S_MEAN_W: begin
        if (stat.div_done) state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_ROOT_W;
      end
      S_ROOT_W: begin
        if (stat.sqrt_done) state_next = S_SD;
      end
      S_SD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SD;
        state_next    = S_SD_W;
      end
      S_SD_W: begin
        if (stat.div_done) state_next = (stat.op == OP_GROWTH) ? S_ACC0 : S_DONE;
      end
      S_ACC0: begin
        cmd.acc_start = 1'b1;
        cmd.acc_early = 1'b1;
        state_next    = S_ACC0_W;
      end
      S_ACC0_W: begin
        if (stat.acc_done) state_next = S_GROW;
      end
      S_GROW: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_GROWTH;
        state_next    = S_GROW_W;
      end
      S_GROW_W: begin
        if (stat.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/daily_series_window_statistics_core.sv -----
// One request is in flight at a time.
// The window walk reads the day store once per cycle; the divider yields one bit per cycle
// and the square root two radicand bits per cycle. A finished result waits in the output register.
// Reset clears the stored day count and the controller; the day store holds no reset value.
`default_nettype none

`include "daily_series_window_statistics_core_macros.svh"

module daily_series_window_statistics_core #(
  parameter int unsigned MAX_DAYS   = dswc_pkg::MAX_DAYS_DEF,
  parameter int unsigned COUNT_BITS = dswc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // day, window_length, growth_interval, new_deaths, new_cases, zero fill
  input  logic [dswc_pkg::S_TDATA_W-1:0]   s_tdata,
  // op, kind
  input  logic [dswc_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status, window_sum, mean_q8, stddev_q8, growth_q8, growth_infinite, days_stored, zero fill
  output logic [dswc_pkg::M_TDATA_W-1:0]   m_tdata
);

  import dswc_pkg::*;

  cmd_t                  cmd;
  stat_t                 stat;
  logic [STATUS_W-1:0]   out_status;
  logic [WSUM_W-1:0]     out_wsum;
  logic [MEAN_W-1:0]     out_mean;
  logic [SD_W-1:0]       out_sd;
  logic [GROWTH_W-1:0]   out_growth;
  logic                  out_inf;
  logic [DAYS_W-1:0]     out_days;

  dswc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  dswc_datapath #(
    .MAX_DAYS  (MAX_DAYS),
    .COUNT_BITS(COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .op             (s_tuser[U_OP_LO +: OP_W]),
    .day            (s_tdata[IN_DAY_LO +: DAY_W]),
    .window_length  (s_tdata[IN_WIN_LO +: WIN_W]),
    .growth_interval(s_tdata[IN_GAP_LO +: GAP_W]),
    .kind           (s_tuser[U_KIND_BIT]),
    .new_deaths     (s_tdata[IN_ND_LO +: IN_CNT_W]),
    .new_cases      (s_tdata[IN_NC_LO +: IN_CNT_W]),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .out_status     (out_status),
    .out_wsum       (out_wsum),
    .out_mean       (out_mean),
    .out_sd         (out_sd),
    .out_growth     (out_growth),
    .out_inf        (out_inf),
    .out_days       (out_days)
  );

  assign m_tdata = {2'b00, out_days, out_inf, out_growth, out_sd, out_mean, out_wsum,
                    out_status};

  `DSWC_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "request not held off while busy")
  `DSWC_ASSERT_NOW(a_days_in_range, m_tvalid, m_tdata[O_DAYS_LO +: DAYS_W] <= MAX_DAYS, "days stored beyond capacity")
  `DSWC_ASSERT_NOW(a_error_clears_fields, m_tvalid && (m_tdata[O_STATUS_LO +: STATUS_W] != ST_OK), m_tdata[O_DAYS_LO-1:O_WSUM_LO] == '0, "error result carries nonzero fields")

endmodule

`default_nettype wire
